// ===== design/link_protocol_receiver_top_macros.svh =====
// Assertion macros for the link protocol receiver.
// Used by link_protocol_receiver_top; needs a clock and reset in scope.
`ifndef LINK_PROTOCOL_RECEIVER_TOP_MACROS_SVH
`define LINK_PROTOCOL_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define LPR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define LPR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lpr_pkg.sv =====
// Link protocol receiver package: transaction types, control characters,
// mode and action codes, and the byte-wide CRC-32 update.
// No dependencies.
`default_nettype none

package lpr_pkg;

   localparam int PAYLOAD_BYTES = 512;
   localparam int POS_W = $clog2(PAYLOAD_BYTES + 6);

   localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_HDR   = POS_W'(1);
   localparam logic [POS_W-1:0] POS_DATA  = POS_W'(2);
   localparam logic [POS_W-1:0] POS_TRAIL = POS_W'(PAYLOAD_BYTES + 2);
   localparam logic [POS_W-1:0] POS_LAST  = POS_W'(PAYLOAD_BYTES + 5);

   localparam logic [7:0] CH_SYN = 8'h16;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_ENQ = 8'h05;
   localparam logic [7:0] CH_ACK = 8'h06;

   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_SEND = 2'd1;
   localparam logic [1:0] FUNC_TICK = 2'd2;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_RECV = 2'd1;
   localparam logic [1:0] MODE_BID  = 2'd2;
   localparam logic [1:0] MODE_SEND = 2'd3;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_ACK  = 2'd1;
   localparam logic [1:0] ACT_ENQ  = 2'd2;
   localparam logic [1:0] ACT_XMIT = 2'd3;

   localparam logic [15:0] TIMEOUT_RESET = 16'd2000;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] action;
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       frame_end;
      logic       crc_ok;
      logic [1:0] link_state;
   } rsp_type;

   // reflected CRC-32, one byte
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== design/link_protocol_receiver_top.sv =====
// Link protocol receiver top level: link mode machine, frame tracker and CRC check.
// Depends on lpr_pkg and link_protocol_receiver_top_macros.svh.
`default_nettype none
`include "link_protocol_receiver_top_macros.svh"

// One request transaction (byte, send request or timer tick) is taken per clock while
// req_ready is high and yields exactly one response from the response register.
// The mode, frame and CRC state update in the same cycle the request is taken; the
// longest path is the byte-wide CRC-32 update (eight folded polynomial steps) into the
// CRC register. A new request is accepted whenever the response register is
// empty or is being drained that cycle, so sustained throughput is one transaction
// per clock. timeout_ticks is written through csr_we/csr_wdata and resets to 2000.
module link_protocol_receiver_top import lpr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata
);

   logic [15:0]      timeout_ticks_ff;
   logic [1:0]       mode_ff, mode_in;
   logic             pair_ff, pair_in;
   logic             first_syn_ff, first_syn_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      trailer_ff, trailer_in;
   logic [15:0]      tleft_ff, tleft_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             accept;
   logic [1:0]       new_mode;
   logic             mode_change;
   logic [31:0]      crc_upd;
   logic [31:0]      trailer_upd;
   logic [15:0]      tleft_dec;
   logic [7:0]       b;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign b           = req_data.rx_byte;
   assign crc_upd     = crc32_byte(crc_ff, b);
   assign trailer_upd = {trailer_ff[23:0], b};
   assign tleft_dec   = (tleft_ff != 16'd0) ? (tleft_ff - 16'd1) : tleft_ff;

   always_comb begin
      new_mode     = mode_ff;
      pair_in      = pair_ff;
      first_syn_in = first_syn_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      trailer_in   = trailer_ff;
      tleft_in     = tleft_ff;
      rsp_in       = '0;

      case (req_data.func)
         FUNC_BYTE: begin
            case (mode_ff)
               MODE_IDLE, MODE_BID: begin
                  if (!pair_ff) begin
                     if (b == CH_SYN) pair_in = 1'b1;
                  end else begin
                     pair_in = 1'b0;
                     if (mode_ff == MODE_IDLE && b == CH_ENQ) begin
                        rsp_in.action = ACT_ACK;
                        new_mode      = MODE_RECV;
                     end else if (mode_ff == MODE_BID && b == CH_ACK) begin
                        rsp_in.action = ACT_XMIT;
                        tleft_in      = timeout_ticks_ff;
                        new_mode      = MODE_SEND;
                     end
                  end
               end
               MODE_SEND: begin
                  if (!pair_ff) begin
                     pair_in      = 1'b1;
                     first_syn_in = (b == CH_SYN);
                  end else begin
                     pair_in = 1'b0;
                     if (first_syn_ff && b == CH_ACK) tleft_in = timeout_ticks_ff;
                     first_syn_in = 1'b0;
                  end
               end
               default: begin
                  if (pos_ff == POS_HUNT) begin
                     if (b == CH_SYN) pos_in = POS_HDR;
                  end else if (pos_ff == POS_HDR) begin
                     if (b == CH_STX) begin
                        pos_in     = POS_DATA;
                        crc_in     = CRC_INIT;
                        trailer_in = 32'd0;
                     end else begin
                        pos_in = POS_HUNT;
                     end
                  end else if (pos_ff < POS_TRAIL) begin
                     rsp_in.payload_valid = 1'b1;
                     rsp_in.payload_byte  = b;
                     crc_in               = crc_upd;
                     pos_in               = pos_ff + POS_W'(1);
                  end else begin
                     trailer_in = trailer_upd;
                     if (pos_ff >= POS_LAST) begin
                        rsp_in.frame_end = 1'b1;
                        rsp_in.crc_ok    = ((crc_ff ^ CRC_INIT) == trailer_upd);
                        if ((crc_ff ^ CRC_INIT) == trailer_upd) rsp_in.action = ACT_ACK;
                        pos_in     = POS_HUNT;
                        crc_in     = CRC_INIT;
                        trailer_in = 32'd0;
                     end else begin
                        pos_in = pos_ff + POS_W'(1);
                     end
                  end
               end
            endcase
         end
         FUNC_SEND: begin
            case (mode_ff)
               MODE_IDLE: begin
                  rsp_in.action = ACT_ENQ;
                  tleft_in      = timeout_ticks_ff;
                  new_mode      = MODE_BID;
               end
               MODE_RECV: rsp_in.action = ACT_ACK;
               MODE_BID:  rsp_in.action = ACT_ENQ;
               default:   rsp_in.action = ACT_XMIT;
            endcase
         end
         FUNC_TICK: begin
            if (mode_ff == MODE_BID || mode_ff == MODE_SEND) begin
               tleft_in = tleft_dec;
               if (tleft_dec == 16'd0) new_mode = MODE_IDLE;
            end
         end
         default: ;
      endcase

      mode_change = (new_mode != mode_ff);
      if (mode_change) begin
         pair_in      = 1'b0;
         first_syn_in = 1'b0;
         if (new_mode == MODE_RECV) begin
            pos_in     = POS_HUNT;
            crc_in     = CRC_INIT;
            trailer_in = 32'd0;
         end
      end
      mode_in           = new_mode;
      rsp_in.link_state = new_mode;
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= TIMEOUT_RESET;
         mode_ff          <= MODE_IDLE;
         pair_ff          <= 1'b0;
         first_syn_ff     <= 1'b0;
         pos_ff           <= POS_HUNT;
         crc_ff           <= CRC_INIT;
         trailer_ff       <= 32'd0;
         tleft_ff         <= 16'd0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we) timeout_ticks_ff <= csr_wdata;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff      <= mode_in;
            pair_ff      <= pair_in;
            first_syn_ff <= first_syn_in;
            pos_ff       <= pos_in;
            crc_ff       <= crc_in;
            trailer_ff   <= trailer_in;
            tleft_ff     <= tleft_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   `LPR_ASSERT_NOW(a_payload_in_recv, rsp_valid_ff && rsp_ff.payload_valid,
      rsp_ff.link_state == MODE_RECV, "payload byte outside receive mode")
   `LPR_ASSERT_NOW(a_frame_end_ack, rsp_valid_ff && rsp_ff.frame_end,
      rsp_ff.crc_ok == (rsp_ff.action == ACT_ACK), "frame end ack does not follow crc check")
   `LPR_ASSERT_NOW(a_pos_range, 1'b1, pos_ff <= POS_LAST, "frame position out of range")
   `LPR_ASSERT_NEXT(a_state_mirrors_rsp, accept, rsp_ff.link_state == mode_ff,
      "reported mode differs from held mode")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for link_protocol_receiver_top: link modes, frame CRC check, timeouts.
// Depends on lpr_pkg and the design sources; compares every response transaction with
// a behavioral model of the link machine kept in this file.
module testbench import lpr_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   link_protocol_receiver_top dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_we, .csr_wdata
   );

   // link machine model state
   logic [1:0]  link_mode_q = MODE_IDLE;
   logic        pair_open = 1'b0;
   logic        lead_was_syn = 1'b0;
   int          frame_pos = 0;
   logic [31:0] crc_run = CRC_INIT;
   logic [31:0] trailer_word = '0;
   logic [15:0] ticks_left = '0;
   logic [15:0] timeout_cfg = TIMEOUT_RESET;

   req_type     line_traffic[$];
   rsp_type     link_replies[$];
   int unsigned traffic_sent = 0;
   int unsigned traffic_taken = 0;
   int unsigned fault_count = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   bit          last_byte_syn = 1'b0;
   logic        calm_stretch;

   assign calm_stretch = (cycle_count % 1000) >= 700;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // reflected CRC-32, one data bit at a time
   function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb = acc[0] ^ d[i];
         acc = (acc >> 1) ^ (fb ? CRC_POLY : 32'd0);
      end
      return acc;
   endfunction

   function automatic void switch_mode(input logic [1:0] m);
      link_mode_q = m;
      pair_open = 1'b0;
      lead_was_syn = 1'b0;
      if (m == MODE_RECV) begin
         frame_pos = 0;
         crc_run = CRC_INIT;
         trailer_word = '0;
      end
   endfunction

   function automatic rsp_type link_step(input req_type r);
      rsp_type o;
      o = '0;
      case (r.func)
         FUNC_BYTE: begin
            case (link_mode_q)
               MODE_IDLE, MODE_BID: begin
                  if (!pair_open) begin
                     if (r.rx_byte == CH_SYN) pair_open = 1'b1;
                  end else begin
                     pair_open = 1'b0;
                     if (link_mode_q == MODE_IDLE && r.rx_byte == CH_ENQ) begin
                        o.action = ACT_ACK;
                        switch_mode(MODE_RECV);
                     end else if (link_mode_q == MODE_BID && r.rx_byte == CH_ACK) begin
                        o.action = ACT_XMIT;
                        ticks_left = timeout_cfg;
                        switch_mode(MODE_SEND);
                     end
                  end
               end
               MODE_SEND: begin
                  if (!pair_open) begin
                     pair_open = 1'b1;
                     lead_was_syn = (r.rx_byte == CH_SYN);
                  end else begin
                     pair_open = 1'b0;
                     if (lead_was_syn && r.rx_byte == CH_ACK) ticks_left = timeout_cfg;
                     lead_was_syn = 1'b0;
                  end
               end
               default: begin
                  if (frame_pos == 0) begin
                     if (r.rx_byte == CH_SYN) frame_pos = 1;
                  end else if (frame_pos == 1) begin
                     if (r.rx_byte == CH_STX) begin
                        frame_pos = 2;
                        crc_run = CRC_INIT;
                        trailer_word = '0;
                     end else begin
                        frame_pos = 0;
                     end
                  end else if (frame_pos < PAYLOAD_BYTES + 2) begin
                     o.payload_valid = 1'b1;
                     o.payload_byte = r.rx_byte;
                     crc_run = crc_step(crc_run, r.rx_byte);
                     frame_pos++;
                  end else begin
                     trailer_word = {trailer_word[23:0], r.rx_byte};
                     if (frame_pos >= PAYLOAD_BYTES + 5) begin
                        o.frame_end = 1'b1;
                        o.crc_ok = (~crc_run == trailer_word);
                        if (o.crc_ok) o.action = ACT_ACK;
                        frame_pos = 0;
                        crc_run = CRC_INIT;
                        trailer_word = '0;
                     end else begin
                        frame_pos++;
                     end
                  end
               end
            endcase
         end
         FUNC_SEND: begin
            case (link_mode_q)
               MODE_IDLE: begin
                  o.action = ACT_ENQ;
                  ticks_left = timeout_cfg;
                  switch_mode(MODE_BID);
               end
               MODE_RECV: o.action = ACT_ACK;
               MODE_BID:  o.action = ACT_ENQ;
               default:   o.action = ACT_XMIT;
            endcase
         end
         FUNC_TICK: begin
            if (link_mode_q == MODE_BID || link_mode_q == MODE_SEND) begin
               if (ticks_left != 0) ticks_left--;
               if (ticks_left == 0) switch_mode(MODE_IDLE);
            end
         end
         default: ;
      endcase
      o.link_state = link_mode_q;
      return o;
   endfunction

   // sender side
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            link_replies = {link_replies, link_step(req_data)};
            traffic_taken++;
         end
         if (!req_valid || req_ready) begin
            if (line_traffic.size() > 0 && (calm_stretch || $urandom_range(0, 99) >= 8)) begin
               req_data <= line_traffic.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         fault_count++;
         $display("time %0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   // receiver side
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (link_replies.size() == 0) begin
               fault_count++;
               $display("time %0t: response %h with no transaction outstanding",
                        $time, rsp_data);
            end else begin
               want = link_replies.pop_front();
               report_field("action", 32'(want.action), 32'(rsp_data.action));
               report_field("payload_valid", 32'(want.payload_valid),
                            32'(rsp_data.payload_valid));
               report_field("payload_byte", 32'(want.payload_byte),
                            32'(rsp_data.payload_byte));
               report_field("frame_end", 32'(want.frame_end), 32'(rsp_data.frame_end));
               report_field("crc_ok", 32'(want.crc_ok), 32'(rsp_data.crc_ok));
               report_field("link_state", 32'(want.link_state), 32'(rsp_data.link_state));
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (line_traffic.size() > 200 && (cycle_count % 128) == 0) begin
            hold_left <= 48;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm_stretch || $urandom_range(0, 99) >= 8;
         end
      end
   end

   task automatic push_req(input logic [1:0] f, input logic [7:0] b);
      req_type r;
      r.func = f;
      r.rx_byte = b;
      line_traffic = {line_traffic, r};
      traffic_sent++;
      if (f == FUNC_BYTE) last_byte_syn = (b == CH_SYN);
   endtask

   task automatic wait_drained();
      while (traffic_taken != traffic_sent || link_replies.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [15:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      timeout_cfg = v;
   endtask

   // from bid or send: short timeout, SYN ACK to load it, one tick
   task automatic return_to_idle();
      wait_drained();
      if (link_mode_q != MODE_IDLE) begin
         write_timeout(16'd1);
         if (pair_open) push_req(FUNC_BYTE, 8'h00);
         push_req(FUNC_BYTE, CH_SYN);
         push_req(FUNC_BYTE, CH_ACK);
         push_req(FUNC_TICK, 8'($urandom));
         wait_drained();
      end
   endtask

   // bidding and sending traffic; a SYN ENQ pair is never formed so receive is not entered
   task automatic push_link_traffic(input int n);
      int sel;
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(0, 99);
         if (sel < 25) begin
            push_req(FUNC_SEND, 8'($urandom));
         end else if (sel < 50) begin
            push_req(FUNC_TICK, 8'($urandom));
         end else if (sel < 55) begin
            push_req(FUNC_UNUSED, 8'($urandom));
         end else if (sel < 80) begin
            push_req(FUNC_BYTE, CH_SYN);
            push_req(FUNC_BYTE, CH_ACK);
         end else begin
            b = 8'($urandom);
            if (last_byte_syn && b == CH_ENQ) b = CH_ACK;
            push_req(FUNC_BYTE, b);
         end
      end
   endtask

   task automatic push_frame(input bit crc_good);
      logic [31:0] acc;
      logic [31:0] fcs;
      logic [7:0]  b;
      int          pick;
      acc = CRC_INIT;
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, CH_STX);
      for (int k = 0; k < PAYLOAD_BYTES; k++) begin
         b = 8'($urandom);
         acc = crc_step(acc, b);
         push_req(FUNC_BYTE, b);
         if ($urandom_range(0, 99) < 3) begin
            pick = $urandom_range(0, 2);
            push_req(pick == 0 ? FUNC_SEND : (pick == 1 ? FUNC_TICK : FUNC_UNUSED),
                     8'($urandom));
         end
      end
      fcs = ~acc;
      if (!crc_good) fcs ^= 32'd1 << $urandom_range(0, 31);
      push_req(FUNC_BYTE, fcs[31:24]);
      push_req(FUNC_BYTE, fcs[23:16]);
      push_req(FUNC_BYTE, fcs[15:8]);
      push_req(FUNC_BYTE, fcs[7:0]);
   endtask

   initial begin : stimulus
      logic [15:0] phase_timeout[5];
      phase_timeout = '{16'd0, 16'd1, 16'd4, 16'hFFFF, 16'd12};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // idle hunting, bid and send, reset timeout
      push_req(FUNC_UNUSED, 8'hFF);
      push_req(FUNC_TICK, 8'h00);
      push_req(FUNC_BYTE, 8'h00);
      push_req(FUNC_BYTE, 8'hFF);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, 8'hFF);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, CH_ENQ);
      push_req(FUNC_SEND, 8'h00);
      push_req(FUNC_SEND, 8'hFF);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, CH_ENQ);
      push_req(FUNC_BYTE, 8'h00);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, CH_ACK);
      push_req(FUNC_SEND, 8'h00);
      push_req(FUNC_BYTE, 8'hFF);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, CH_ACK);
      push_req(FUNC_TICK, 8'hFF);
      return_to_idle();

      foreach (phase_timeout[p]) begin
         return_to_idle();
         write_timeout(phase_timeout[p]);
         push_link_traffic(20);
      end

      // into receive with a tick between SYN and ENQ; receive is never left
      return_to_idle();
      write_timeout(16'($urandom_range(1, 65535)));
      if (pair_open) push_req(FUNC_BYTE, 8'h00);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_TICK, 8'h00);
      push_req(FUNC_BYTE, CH_ENQ);
      push_req(FUNC_SEND, 8'h00);
      push_req(FUNC_TICK, 8'hFF);
      push_req(FUNC_UNUSED, 8'h00);
      push_req(FUNC_BYTE, 8'h00);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, CH_STX);
      push_req(FUNC_BYTE, CH_SYN);
      push_req(FUNC_BYTE, 8'hFF);
      push_frame(1'b1);
      push_req(FUNC_BYTE, 8'($urandom));
      push_req(FUNC_BYTE, 8'($urandom));
      push_frame(1'b0);
      for (int i = 0; i < 20; i++) push_req(FUNC_BYTE, 8'($urandom));

      wait_drained();
      repeat (4) @(posedge clock);
      if (fault_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/lpr_pkg.sv
design/link_protocol_receiver_top.sv
sim/testbench.sv
